/* design/cbspl_pkg.sv */
// package for the cubic b-spline point and tangent core
// widths, control word types and the microcode program
// no dependencies
`default_nettype none

package cbspl_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_BITS = 24;
    localparam int T_W        = FRAC_BITS + 1;
    localparam int OUT_W      = 32;

    // multiplier operand and product widths
    localparam int A_W    = (COORD_BITS + 6 > FRAC_BITS + 2) ? COORD_BITS + 6 : FRAC_BITS + 2;
    localparam int LIMB_W = (3 * FRAC_BITS + 2) / 2;
    localparam int P_W    = A_W + LIMB_W + 1;

    // exact sums and quotient widths
    localparam int ACC_W      = COORD_BITS + 3 * FRAC_BITS + 8;
    localparam int DIGIT_W    = 8;
    localparam int Q_W        = ((ACC_W - 2 * FRAC_BITS + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
    localparam int DIV_STEPS  = Q_W / DIGIT_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam logic [3:0] DIVISOR = 4'd6;

    localparam logic [T_W-1:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    localparam int UC_DEPTH = 18;
    localparam int PC_W     = $clog2(UC_DEPTH);

    localparam logic [PC_W-1:0] PC_REJOIN  = PC_W'(6);
    localparam logic [PC_W-1:0] PC_Y_ENTRY = PC_W'(15);

    typedef enum logic [2:0] {
        A_T,
        A_A1,
        A_A2,
        A_A2X2,
        A_A3,
        A_A3X3
    } a_sel_t;

    typedef enum logic [2:0] {
        B_T,
        B_T2_LO,
        B_T2_HI,
        B_T3_LO,
        B_T3_HI
    } b_sel_t;

    typedef enum logic [2:0] {
        AD_NONE,
        AD_POS,
        AD_TAN,
        AD_T2,
        AD_T3
    } acc_dst_t;

    typedef enum logic [2:0] {
        SH_0,
        SH_L,
        SH_F,
        SH_FL,
        SH_2F
    } shift_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INIT,
        OP_DIV_POS,
        OP_DIV_TAN,
        OP_FIN
    } op_t;

    typedef enum logic [1:0] {
        JC_NEXT,
        JC_JUMP,
        JC_AXIS
    } jc_t;

    typedef struct packed {
        a_sel_t          a_sel;
        b_sel_t          b_sel;
        acc_dst_t        dst;
        logic            clr;
        shift_t          sh;
        op_t             op;
        jc_t             jc;
        logic [PC_W-1:0] target;
    } ucode_t;

    // acc fields act on the product issued by the step before
    function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
        ucode_t u;
        u.a_sel  = A_T;
        u.b_sel  = B_T;
        u.dst    = AD_NONE;
        u.clr    = 1'b0;
        u.sh     = SH_0;
        u.op     = OP_NONE;
        u.jc     = JC_NEXT;
        u.target = '0;
        case (pc)
            PC_W'(0):
            begin
                u.op = OP_INIT;
                u.a_sel = A_T;     u.b_sel = B_T;
            end
            PC_W'(1):
            begin
                u.dst = AD_T2;  u.clr = 1'b1;  u.sh = SH_0;
                u.a_sel = A_A1;    u.b_sel = B_T;
            end
            PC_W'(2):
            begin
                u.dst = AD_POS; u.sh = SH_2F;
                u.a_sel = A_T;     u.b_sel = B_T2_LO;
            end
            PC_W'(3):
            begin
                u.dst = AD_T3;  u.clr = 1'b1;  u.sh = SH_0;
                u.a_sel = A_T;     u.b_sel = B_T2_HI;
            end
            PC_W'(4):
            begin
                u.dst = AD_T3;  u.sh = SH_L;
                u.a_sel = A_A2X2;  u.b_sel = B_T;
            end
            PC_W'(5):
            begin
                u.dst = AD_TAN; u.sh = SH_F;
                u.a_sel = A_A2;    u.b_sel = B_T2_LO;
            end
            PC_W'(6):
            begin
                u.dst = AD_POS; u.sh = SH_F;
                u.a_sel = A_A2;    u.b_sel = B_T2_HI;
            end
            PC_W'(7):
            begin
                u.dst = AD_POS; u.sh = SH_FL;
                u.a_sel = A_A3X3;  u.b_sel = B_T2_LO;
            end
            PC_W'(8):
            begin
                u.dst = AD_TAN; u.sh = SH_0;
                u.a_sel = A_A3X3;  u.b_sel = B_T2_HI;
            end
            PC_W'(9):
            begin
                u.dst = AD_TAN; u.sh = SH_L;
                u.a_sel = A_A3;    u.b_sel = B_T3_LO;
            end
            PC_W'(10):
            begin
                u.dst = AD_POS; u.sh = SH_0;
                u.a_sel = A_A3;    u.b_sel = B_T3_HI;
            end
            PC_W'(11):
            begin
                u.dst = AD_POS; u.sh = SH_L;
            end
            PC_W'(12):
            begin
                u.op = OP_DIV_POS;
            end
            PC_W'(13):
            begin
                u.op = OP_DIV_TAN;
                u.jc = JC_AXIS;  u.target = PC_Y_ENTRY;
            end
            PC_W'(14):
            begin
                u.op = OP_FIN;
            end
            PC_W'(15):
            begin
                u.op = OP_INIT;
                u.a_sel = A_A1;    u.b_sel = B_T;
            end
            PC_W'(16):
            begin
                u.dst = AD_POS; u.sh = SH_2F;
                u.a_sel = A_A2X2;  u.b_sel = B_T;
            end
            PC_W'(17):
            begin
                u.dst = AD_TAN; u.sh = SH_F;
                u.a_sel = A_A2;    u.b_sel = B_T2_LO;
                u.jc = JC_JUMP;  u.target = PC_REJOIN;
            end
            default:
            begin
                u.op = OP_NONE;
            end
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

/* design/cbspl_div6.sv */
// divide-by-six unit, eight quotient bits per cycle
// uses cbspl_pkg for widths and the divisor
`default_nettype none

module cbspl_div6 (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [cbspl_pkg::Q_W-1:0] num,
    output logic                          done,
    output logic [cbspl_pkg::Q_W-1:0]     quo
);

    logic [cbspl_pkg::Q_W-1:0]       work_reg;
    logic [2:0]                      rem_reg;
    logic [cbspl_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;

    logic [cbspl_pkg::DIGIT_W-1:0]   qbits_next;
    logic [2:0]                      rem_next;

    always_comb
    begin
        logic [3:0] cur;
        logic [2:0] r;
        r = rem_reg;
        qbits_next = '0;
        for (int i = 0; i < cbspl_pkg::DIGIT_W; i++)
        begin
            cur = {r, work_reg[cbspl_pkg::Q_W-1-i]};
            if (cur >= cbspl_pkg::DIVISOR)
            begin
                qbits_next[cbspl_pkg::DIGIT_W-1-i] = 1'b1;
                r = 3'(cur - cbspl_pkg::DIVISOR);
            end
            else
            begin
                r = cur[2:0];
            end
        end
        rem_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            work_reg <= num;
            rem_reg  <= 3'd0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[cbspl_pkg::Q_W-cbspl_pkg::DIGIT_W-1:0], qbits_next};
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_reg + 1'b1;
            if (cnt_reg == cbspl_pkg::DIV_CNT_W'(cbspl_pkg::DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign quo  = work_reg;

endmodule

`default_nettype wire

/* design/cubic_bspline_point_and_tangent_core.sv */
// cubic b-spline point and tangent core, microcoded over one shared multiplier
// sequence: an evaluate beat runs its products on the shared multiplier, then makes
//   four passes through the divide-by-six unit, for position and tangent of each axis
// throughput: one push per cycle while no evaluate runs; a new evaluate is taken only after the last one finishes
// reset: asynchronous active low, clears the point window to zero and idles the sequencer
// uses cbspl_pkg and cbspl_div6
`default_nettype none

module cubic_bspline_point_and_tangent_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                mode,
    input  wire logic signed [cbspl_pkg::COORD_BITS-1:0] point_x,
    input  wire logic signed [cbspl_pkg::COORD_BITS-1:0] point_y,
    input  wire logic [cbspl_pkg::T_W-1:0]           param_t,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [cbspl_pkg::OUT_W-1:0]       pos_x,
    output logic signed [cbspl_pkg::OUT_W-1:0]       pos_y,
    output logic signed [cbspl_pkg::OUT_W-1:0]       tan_x,
    output logic signed [cbspl_pkg::OUT_W-1:0]       tan_y
);

    localparam int F  = cbspl_pkg::FRAC_BITS;
    localparam int L  = cbspl_pkg::LIMB_W;
    localparam int AW = cbspl_pkg::ACC_W;

    logic signed [cbspl_pkg::COORD_BITS-1:0] win_x_reg [4];
    logic signed [cbspl_pkg::COORD_BITS-1:0] win_y_reg [4];

    logic [cbspl_pkg::T_W-1:0]       t_reg;
    logic [2*F:0]                    t2_reg;
    logic [3*F:0]                    t3_reg;
    logic [2*F:0]                    t2_next;
    logic [3*F:0]                    t3_next;
    logic [cbspl_pkg::PC_W-1:0]      pc_reg;
    logic [cbspl_pkg::PC_W-1:0]      pc_next;
    logic                            run_reg;
    logic                            axis_reg;
    logic                            axis_next;
    logic                            dwait_reg;
    logic                            dneg_reg;
    logic signed [cbspl_pkg::P_W-1:0] prod_reg;
    logic signed [cbspl_pkg::P_W-1:0] prod_next;
    logic signed [AW-1:0]            pos_acc_reg;
    logic signed [AW-1:0]            pos_acc_next;
    logic signed [AW-1:0]            tan_acc_reg;
    logic signed [AW-1:0]            tan_acc_next;

    logic signed [cbspl_pkg::OUT_W-1:0] px_reg, tx_reg, py_reg, ty_reg;
    logic signed [cbspl_pkg::OUT_W-1:0] pos_x_reg, pos_y_reg, tan_x_reg, tan_y_reg;
    logic                               out_valid_reg;

    cbspl_pkg::ucode_t uw;

    logic signed [cbspl_pkg::A_W-1:0] e0, e1, e2, e3;
    logic signed [cbspl_pkg::A_W-1:0] a0, a1, a2, a3, s2, d13;
    logic signed [cbspl_pkg::A_W-1:0] a_op;
    logic [L-1:0]                     b_op;
    logic [2*L-1:0]                   t2_ext, t3_ext;

    logic signed [AW-1:0] addend, base, acc_sum;

    logic                       in_fire;
    logic                       step_go;
    logic                       fin_go;
    logic                       is_div;
    logic                       div_start;
    logic                       div_done;
    logic [cbspl_pkg::Q_W-1:0]  div_quo;
    logic [cbspl_pkg::Q_W-1:0]  dnum;
    logic signed [AW-1:0]       dsel;
    logic                       dneg;
    logic [AW:0]                half, dext, magsum, mshift;
    logic [cbspl_pkg::T_W-1:0]  t_clamp;
    logic signed [cbspl_pkg::OUT_W-1:0] res32;

    assign uw       = cbspl_pkg::ucode(pc_reg);
    assign in_ready = !run_reg;
    assign in_fire  = in_valid && in_ready;
    assign t_clamp  = (param_t > cbspl_pkg::T_ONE) ? cbspl_pkg::T_ONE : param_t;

    // coefficients of the active axis, each times six
    always_comb
    begin
        if (axis_reg)
        begin
            e0 = cbspl_pkg::A_W'(win_y_reg[0]);
            e1 = cbspl_pkg::A_W'(win_y_reg[1]);
            e2 = cbspl_pkg::A_W'(win_y_reg[2]);
            e3 = cbspl_pkg::A_W'(win_y_reg[3]);
        end
        else
        begin
            e0 = cbspl_pkg::A_W'(win_x_reg[0]);
            e1 = cbspl_pkg::A_W'(win_x_reg[1]);
            e2 = cbspl_pkg::A_W'(win_x_reg[2]);
            e3 = cbspl_pkg::A_W'(win_x_reg[3]);
        end
        d13 = e1 - e2;
        a3  = (e3 - e0) + (d13 <<< 1) + d13;
        s2  = e0 - (e1 <<< 1) + e2;
        a2  = s2 + (s2 <<< 1);
        a1  = (e2 - e0) + ((e2 - e0) <<< 1);
        a0  = e0 + (e1 <<< 2) + e2;
    end

    // shared multiplier operands
    assign t2_ext = (2*L)'(t2_reg);
    assign t3_ext = (2*L)'(t3_reg);

    always_comb
    begin
        case (uw.a_sel)
            cbspl_pkg::A_T:    a_op = cbspl_pkg::A_W'(t_reg);
            cbspl_pkg::A_A1:   a_op = a1;
            cbspl_pkg::A_A2:   a_op = a2;
            cbspl_pkg::A_A2X2: a_op = a2 <<< 1;
            cbspl_pkg::A_A3:   a_op = a3;
            cbspl_pkg::A_A3X3: a_op = a3 + (a3 <<< 1);
            default:           a_op = '0;
        endcase
        case (uw.b_sel)
            cbspl_pkg::B_T:     b_op = L'(t_reg);
            cbspl_pkg::B_T2_LO: b_op = t2_ext[L-1:0];
            cbspl_pkg::B_T2_HI: b_op = t2_ext[2*L-1:L];
            cbspl_pkg::B_T3_LO: b_op = t3_ext[L-1:0];
            cbspl_pkg::B_T3_HI: b_op = t3_ext[2*L-1:L];
            default:            b_op = '0;
        endcase
    end

    assign prod_next = a_op * $signed({1'b0, b_op});

    // accumulate the previous product
    always_comb
    begin
        case (uw.sh)
            cbspl_pkg::SH_0:  addend = AW'(prod_reg);
            cbspl_pkg::SH_L:  addend = AW'(prod_reg) <<< L;
            cbspl_pkg::SH_F:  addend = AW'(prod_reg) <<< F;
            cbspl_pkg::SH_FL: addend = AW'(prod_reg) <<< (F + L);
            cbspl_pkg::SH_2F: addend = AW'(prod_reg) <<< (2 * F);
            default:          addend = '0;
        endcase
        case (uw.dst)
            cbspl_pkg::AD_POS: base = pos_acc_reg;
            cbspl_pkg::AD_TAN: base = tan_acc_reg;
            cbspl_pkg::AD_T2:  base = AW'(t2_reg);
            cbspl_pkg::AD_T3:  base = AW'(t3_reg);
            default:           base = '0;
        endcase
        if (uw.clr)
        begin
            base = '0;
        end
        acc_sum = base + addend;

        pos_acc_next = pos_acc_reg;
        tan_acc_next = tan_acc_reg;
        t2_next      = t2_reg;
        t3_next      = t3_reg;
        if (uw.op == cbspl_pkg::OP_INIT)
        begin
            pos_acc_next = AW'(a0) <<< (3 * F);
            tan_acc_next = AW'(a1) <<< (2 * F);
        end
        case (uw.dst)
            cbspl_pkg::AD_POS: pos_acc_next = acc_sum;
            cbspl_pkg::AD_TAN: tan_acc_next = acc_sum;
            cbspl_pkg::AD_T2:  t2_next = acc_sum[2*F:0];
            cbspl_pkg::AD_T3:  t3_next = acc_sum[3*F:0];
            default:           t2_next = t2_reg;
        endcase
    end

    // magnitude plus half of the divisor scale, then drop the fraction
    always_comb
    begin
        if (uw.op == cbspl_pkg::OP_DIV_POS)
        begin
            dsel = pos_acc_reg;
            half = (AW+1)'(3) << (3 * F);
        end
        else
        begin
            dsel = tan_acc_reg;
            half = (AW+1)'(3) << (2 * F);
        end
        dneg   = dsel[AW-1];
        dext   = {dsel[AW-1], dsel};
        magsum = dneg ? (half - dext) : (dext + half);
        mshift = (uw.op == cbspl_pkg::OP_DIV_POS) ? (magsum >> (3 * F)) : (magsum >> (2 * F));
        dnum   = mshift[cbspl_pkg::Q_W-1:0];
    end

    assign is_div    = (uw.op == cbspl_pkg::OP_DIV_POS) || (uw.op == cbspl_pkg::OP_DIV_TAN);
    assign div_start = run_reg && is_div && !dwait_reg;

    cbspl_div6 u_div6 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (dnum),
        .done  (div_done),
        .quo   (div_quo)
    );

    // saturate and restore the sign
    always_comb
    begin
        if (dneg_reg)
        begin
            if (div_quo > cbspl_pkg::Q_W'(32'h8000_0000))
            begin
                res32 = 32'sh8000_0000;
            end
            else
            begin
                res32 = -$signed(div_quo[31:0]);
            end
        end
        else
        begin
            if (div_quo > cbspl_pkg::Q_W'(32'h7FFF_FFFF))
            begin
                res32 = 32'sh7FFF_FFFF;
            end
            else
            begin
                res32 = $signed(div_quo[31:0]);
            end
        end
    end

    // sequencer
    always_comb
    begin
        case (uw.op)
            cbspl_pkg::OP_DIV_POS: step_go = dwait_reg && div_done;
            cbspl_pkg::OP_DIV_TAN: step_go = dwait_reg && div_done;
            cbspl_pkg::OP_FIN:     step_go = !out_valid_reg || out_ready;
            default:               step_go = 1'b1;
        endcase
        pc_next   = pc_reg;
        axis_next = axis_reg;
        if (step_go)
        begin
            case (uw.jc)
                cbspl_pkg::JC_NEXT: pc_next = pc_reg + 1'b1;
                cbspl_pkg::JC_JUMP: pc_next = uw.target;
                cbspl_pkg::JC_AXIS:
                begin
                    if (!axis_reg)
                    begin
                        pc_next   = uw.target;
                        axis_next = 1'b1;
                    end
                    else
                    begin
                        pc_next = pc_reg + 1'b1;
                    end
                end
                default: pc_next = pc_reg + 1'b1;
            endcase
        end
    end

    assign fin_go = run_reg && (uw.op == cbspl_pkg::OP_FIN) && step_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                win_x_reg[i] <= '0;
                win_y_reg[i] <= '0;
            end
            run_reg       <= 1'b0;
            pc_reg        <= '0;
            axis_reg      <= 1'b0;
            dwait_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !fin_go)
            begin
                out_valid_reg <= 1'b0;
            end

            if (in_fire)
            begin
                if (mode == cbspl_pkg::MODE_PUSH)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        win_x_reg[i] <= win_x_reg[i+1];
                        win_y_reg[i] <= win_y_reg[i+1];
                    end
                    win_x_reg[3] <= point_x;
                    win_y_reg[3] <= point_y;
                end
                else
                begin
                    t_reg    <= t_clamp;
                    run_reg  <= 1'b1;
                    pc_reg   <= '0;
                    axis_reg <= 1'b0;
                end
            end

            if (run_reg)
            begin
                prod_reg    <= prod_next;
                pos_acc_reg <= pos_acc_next;
                tan_acc_reg <= tan_acc_next;
                t2_reg      <= t2_next;
                t3_reg      <= t3_next;
                pc_reg      <= pc_next;
                axis_reg    <= axis_next;

                if (div_start)
                begin
                    dwait_reg <= 1'b1;
                    dneg_reg  <= dneg;
                end
                if (is_div && step_go)
                begin
                    dwait_reg <= 1'b0;
                    case ({axis_reg, uw.op == cbspl_pkg::OP_DIV_TAN})
                        2'b00:   px_reg <= res32;
                        2'b01:   tx_reg <= res32;
                        2'b10:   py_reg <= res32;
                        default: ty_reg <= res32;
                    endcase
                end
                if (fin_go)
                begin
                    pos_x_reg     <= px_reg;
                    tan_x_reg     <= tx_reg;
                    pos_y_reg     <= py_reg;
                    tan_y_reg     <= ty_reg;
                    out_valid_reg <= 1'b1;
                    run_reg       <= 1'b0;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign tan_x     = tan_x_reg;
    assign tan_y     = tan_y_reg;

endmodule

`default_nettype wire

/* test/cubic_bspline_point_and_tangent_core_tb.sv */
`timescale 1ns / 100ps
// testbench for cubic_bspline_point_and_tangent_core: pushes control points and evaluates
// the curve, checking point and tangent against an exact integer spline predictor
// depends on cbspl_pkg and the core

module cubic_bspline_point_and_tangent_core_tb;

    typedef logic signed [127:0] wide_t;
    typedef logic signed [cbspl_pkg::COORD_BITS-1:0] coord_t;
    typedef logic [3:0][cbspl_pkg::COORD_BITS-1:0] window_t;

    typedef struct {
        logic                      mode;
        coord_t                    px;
        coord_t                    py;
        logic [cbspl_pkg::T_W-1:0] t;
        logic                      drain;
        int                        phase;
    } beat_t;

    typedef struct packed {
        logic signed [cbspl_pkg::OUT_W-1:0] pos_x;
        logic signed [cbspl_pkg::OUT_W-1:0] pos_y;
        logic signed [cbspl_pkg::OUT_W-1:0] tan_x;
        logic signed [cbspl_pkg::OUT_W-1:0] tan_y;
    } curve_sample_t;

    localparam coord_t C_MAX = coord_t'(2 ** (cbspl_pkg::COORD_BITS - 1) - 1);
    localparam coord_t C_MIN = coord_t'(-(2 ** (cbspl_pkg::COORD_BITS - 1)));
    localparam int TOTAL_BEATS = 1500;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic mode = cbspl_pkg::MODE_PUSH;
    coord_t point_x = '0;
    coord_t point_y = '0;
    logic [cbspl_pkg::T_W-1:0] param_t = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [cbspl_pkg::OUT_W-1:0] pos_x;
    logic signed [cbspl_pkg::OUT_W-1:0] pos_y;
    logic signed [cbspl_pkg::OUT_W-1:0] tan_x;
    logic signed [cbspl_pkg::OUT_W-1:0] tan_y;

    beat_t pending_beats[$];
    curve_sample_t expected_samples[$];
    window_t win_x = '0;
    window_t win_y = '0;
    int cur_phase = 0;
    int fill_phase = 0;
    logic fill_drain = 1'b0;
    int accepted_beats = 0;
    int total_beats = 0;
    int mismatch_count = 0;

    cubic_bspline_point_and_tangent_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .point_x   (point_x),
        .point_y   (point_y),
        .param_t   (param_t),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .tan_x     (tan_x),
        .tan_y     (tan_y)
    );

    always #10 clk = ~clk;

    // round(num / (6 * 2^(k*FRAC_BITS))), ties away from zero, saturated to 32 bits
    function automatic logic signed [cbspl_pkg::OUT_W-1:0] round_div6(input wide_t num,
                                                                       input int k);
        wide_t scale;
        wide_t mag;
        wide_t q;
        logic neg;
        scale = wide_t'(6) <<< (k * cbspl_pkg::FRAC_BITS);
        neg = num < 0;
        mag = neg ? -num : num;
        q = (mag + scale / 2) / scale;
        if (!neg && q > wide_t'(64'h7fff_ffff))
            return {1'b0, {(cbspl_pkg::OUT_W - 1){1'b1}}};
        if (neg && q > wide_t'(64'h8000_0000))
            return {1'b1, {(cbspl_pkg::OUT_W - 1){1'b0}}};
        return cbspl_pkg::OUT_W'(neg ? -q : q);
    endfunction

    // returns {point, tangent} for one axis of the window
    function automatic logic [2*cbspl_pkg::OUT_W-1:0] spline_axis(input window_t p,
        input logic [cbspl_pkg::T_W-1:0] t_in);
        wide_t s;
        wide_t t;
        wide_t w[4];
        wide_t v[4];
        wide_t n;
        wide_t d;
        s = wide_t'(1) <<< cbspl_pkg::FRAC_BITS;
        t = (t_in > cbspl_pkg::T_ONE) ? wide_t'(cbspl_pkg::T_ONE) : wide_t'(t_in);
        w[0] = (s - t) * (s - t) * (s - t);
        w[1] = 3 * t * t * t - 6 * t * t * s + 4 * s * s * s;
        w[2] = -3 * t * t * t + 3 * t * t * s + 3 * t * s * s + s * s * s;
        w[3] = t * t * t;
        v[0] = -3 * t * t + 6 * t * s - 3 * s * s;
        v[1] = 9 * t * t - 12 * t * s;
        v[2] = -9 * t * t + 6 * t * s + 3 * s * s;
        v[3] = 3 * t * t;
        n = '0;
        d = '0;
        for (int i = 0; i < 4; i++)
        begin
            n = n + wide_t'($signed(p[i])) * w[i];
            d = d + wide_t'($signed(p[i])) * v[i];
        end
        return {round_div6(n, 3), round_div6(d, 2)};
    endfunction

    function automatic int idle_pct(input int phase, input logic sender);
        case (phase)
            0: return sender ? 29 : 62;
            1: return sender ? 62 : 29;
            default: return 0;
        endcase
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(3))
                    0: return C_MAX;
                    1: return C_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            1, 2: return coord_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic logic [cbspl_pkg::T_W-1:0] rand_t();
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(3))
                    0: return '0;
                    1: return cbspl_pkg::T_W'(1);
                    2: return cbspl_pkg::T_ONE - 1'b1;
                    default: return cbspl_pkg::T_ONE;
                endcase
            end
            1: return cbspl_pkg::T_W'($urandom_range(int'(cbspl_pkg::T_ONE) + 1,
                                                     (1 << cbspl_pkg::T_W) - 1));
            default: return cbspl_pkg::T_W'($urandom_range(0, int'(cbspl_pkg::T_ONE)));
        endcase
    endfunction

    task automatic add_beat(input logic m, input coord_t x, input coord_t y,
                            input logic [cbspl_pkg::T_W-1:0] t);
        beat_t b;
        b.mode = m;
        b.px = x;
        b.py = y;
        b.t = t;
        b.drain = fill_drain;
        b.phase = fill_phase;
        fill_drain = 1'b0;
        pending_beats = {pending_beats, b};
    endtask

    task automatic add_push(input coord_t x, input coord_t y);
        add_beat(cbspl_pkg::MODE_PUSH, x, y, cbspl_pkg::T_W'($urandom));
    endtask

    task automatic add_eval(input logic [cbspl_pkg::T_W-1:0] t);
        add_beat(cbspl_pkg::MODE_EVAL, coord_t'($urandom), coord_t'($urandom), t);
    endtask

    task automatic report_mismatch(input string what, input logic [cbspl_pkg::OUT_W-1:0] got,
                                   input logic [cbspl_pkg::OUT_W-1:0] want);
        mismatch_count++;
        $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        beat_t b;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_beats.size() == 0 ||
                (pending_beats[0].drain && (in_valid || expected_samples.size() != 0)) ||
                $urandom_range(99) < idle_pct(pending_beats[0].phase, 1'b1))
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                b = pending_beats[0];
                pending_beats.delete(0);
                in_valid <= 1'b1;
                mode <= b.mode;
                point_x <= b.px;
                point_y <= b.py;
                param_t <= b.t;
                cur_phase <= b.phase;
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= $urandom_range(99) >= idle_pct(cur_phase, 1'b0);
    end

    // accepted input beats update the window or queue a predicted sample
    always @(posedge clk or negedge rst_n)
    begin
        curve_sample_t want;
        if (!rst_n)
        begin
            win_x <= '0;
            win_y <= '0;
        end
        else if (in_valid && in_ready)
        begin
            accepted_beats++;
            if (mode == cbspl_pkg::MODE_PUSH)
            begin
                win_x <= {point_x, win_x[3:1]};
                win_y <= {point_y, win_y[3:1]};
            end
            else
            begin
                {want.pos_x, want.tan_x} = spline_axis(win_x, param_t);
                {want.pos_y, want.tan_y} = spline_axis(win_y, param_t);
                expected_samples = {expected_samples, want};
            end
        end
    end

    // result beats
    always @(posedge clk)
    begin
        curve_sample_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                report_mismatch("unexpected beat pos_x", pos_x, '0);
            end
            else
            begin
                want = expected_samples[0];
                expected_samples.delete(0);
                if (pos_x !== want.pos_x) report_mismatch("pos_x", pos_x, want.pos_x);
                if (pos_y !== want.pos_y) report_mismatch("pos_y", pos_y, want.pos_y);
                if (tan_x !== want.tan_x) report_mismatch("tan_x", tan_x, want.tan_x);
                if (tan_y !== want.tan_y) report_mismatch("tan_y", tan_y, want.tan_y);
            end
        end
    end

    initial
    begin
        // empty window, then clamped t with every bit set
        add_eval('0);
        add_eval('1);
        // a single point in the window
        add_push(C_MAX, C_MIN);
        add_eval(cbspl_pkg::T_W'(32768));
        // full window at the top of the range
        repeat (4) add_push(C_MAX, C_MAX);
        add_eval('0);
        add_eval(cbspl_pkg::T_ONE);
        add_eval(cbspl_pkg::T_ONE + 1'b1);
        // alternating extremes, wait for the pipe to empty first
        fill_drain = 1'b1;
        add_push(C_MAX, C_MIN);
        add_push(C_MIN, C_MAX);
        add_push(C_MAX, C_MIN);
        add_push(C_MIN, C_MAX);
        add_eval('0);
        add_eval(cbspl_pkg::T_ONE);
        add_eval(cbspl_pkg::T_W'(32768));
        add_eval(cbspl_pkg::T_W'(1));
        add_push('1, '1);
        add_push('0, '0);
        add_eval(cbspl_pkg::T_ONE - 1'b1);

        while (pending_beats.size() < TOTAL_BEATS)
        begin
            fill_phase = (pending_beats.size() < TOTAL_BEATS / 3) ? 0 :
                         (pending_beats.size() < 2 * TOTAL_BEATS / 3) ? 1 : 2;
            fill_drain = ($urandom_range(39) == 0);
            if ($urandom_range(9) < 8)
            begin
                repeat ($urandom_range(1, 4)) add_push(rand_coord(), rand_coord());
                repeat ($urandom_range(1, 3)) add_eval(rand_t());
            end
            else if ($urandom_range(1) == 1)
            begin
                add_eval(rand_t());
            end
            else
            begin
                add_push(rand_coord(), rand_coord());
            end
        end
        total_beats = pending_beats.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_beats < total_beats)
            @(posedge clk);
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
